/* rtl/core/rcc_pkg.sv */
// Shared types and constants of the resize coefficient calculator.
package rcc_pkg;

   localparam int IN_W    = 13;
   localparam int OUT_W   = 11;
   localparam int COEF_W  = 14;
   localparam int SHIFT_W = 2;
   localparam int ERR_W   = 3;
   localparam int WORD_W  = 32;
   localparam int CNT_W   = $clog2(COEF_W);

   localparam logic [IN_W:0]       MAX_IN_SIZE  = (IN_W+1)'(4096);
   localparam logic [OUT_W:0]      MAX_OUT_SIZE = (OUT_W+1)'(1024);
   localparam logic [COEF_W-1:0]   COEF_SAT     = {COEF_W{1'b1}};

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE    = 3'd0,
      ERR_IN_BIG  = 3'd1,
      ERR_OUT_BIG = 3'd2,
      ERR_RATIO   = 3'd3,
      ERR_SMALL   = 3'd4
   } err_code_type;

   typedef struct packed {
      logic [IN_W-1:0]  in_width;
      logic [IN_W-1:0]  in_height;
      logic [OUT_W-1:0] out_width;
      logic [OUT_W-1:0] out_height;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] resize_word;
      logic [ERR_W-1:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic               done;
      err_code_type       err;
      logic [SHIFT_W-1:0] shift;
      logic [COEF_W-1:0]  coef;
   } lane_res_type;

endpackage

/* rtl/core/rcc_lane.sv */
// One axis lane: size checks, prescale selection and restoring coefficient divider.
module rcc_lane
   import rcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic [IN_W-1:0]  in_size,
   input  logic [OUT_W-1:0] out_size,
   output lane_res_type     res
);

   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   err_code_type       err_ff, err_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               sat_ff, sat_in;
   logic               feed_ff, feed_in;
   logic [OUT_W-1:0]   div_ff, div_in;
   logic [OUT_W-1:0]   rem_ff, rem_in;
   logic [COEF_W-1:0]  quo_ff, quo_in;

   logic [IN_W-1:0]    out_ext, s0, s1, s2, sm1;
   logic [IN_W-1:0]    max_out_ext;
   logic               step1, step2;
   logic [OUT_W-1:0]   dm1;
   logic [OUT_W:0]     trial;
   err_code_type       chk;

   always_comb begin
      out_ext     = {{(IN_W-OUT_W){1'b0}}, out_size};
      max_out_ext = {{(IN_W-OUT_W-1){1'b0}}, MAX_OUT_SIZE};
      priority if ({1'b0, in_size} > MAX_IN_SIZE) begin
         chk = ERR_IN_BIG;
      end else if ({1'b0, out_size} > MAX_OUT_SIZE) begin
         chk = ERR_OUT_BIG;
      end else if (in_size < IN_W'(2) || out_size < OUT_W'(2)) begin
         chk = ERR_SMALL;
      end else if ({1'b0, out_size, 2'b00} < {1'b0, in_size}) begin
         chk = ERR_RATIO;
      end else begin
         chk = ERR_NONE;
      end
      s0    = in_size;
      step1 = (s0 > max_out_ext) || ({1'b0, s0} >= {1'b0, out_ext[IN_W-2:0], 1'b0});
      s1    = step1 ? (s0 >> 1) : s0;
      step2 = step1 && ((s1 > max_out_ext) ||
                        ({1'b0, s1} >= {1'b0, out_ext[IN_W-2:0], 1'b0}));
      s2    = step2 ? (s1 >> 1) : s1;
      sm1   = s2 - IN_W'(1);
      dm1   = out_size - OUT_W'(1);
      trial = {rem_ff, feed_ff} - {1'b0, div_ff};
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      shift_in  = shift_ff;
      sat_in    = sat_ff;
      feed_in   = feed_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (load) begin
         active_in = 1'b1;
         cnt_in    = '0;
         err_in    = chk;
         shift_in  = {step2, step1 & ~step2};
         sat_in    = {1'b0, sm1} >= {2'b00, dm1, 1'b0};
         feed_in   = sm1[0];
         div_in    = dm1;
         rem_in    = sm1[OUT_W:1];
         quo_in    = '0;
      end else if (active_ff) begin
         feed_in = 1'b0;
         if (!trial[OUT_W]) begin
            rem_in = trial[OUT_W-1:0];
            quo_in = {quo_ff[COEF_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[OUT_W-2:0], feed_ff};
            quo_in = {quo_ff[COEF_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(COEF_W-1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff   <= cnt_in;
      err_ff   <= err_in;
      shift_ff <= shift_in;
      sat_ff   <= sat_in;
      feed_ff  <= feed_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign res.done  = done_ff;
   assign res.err   = err_ff;
   assign res.shift = shift_ff;
   assign res.coef  = sat_ff ? COEF_SAT : quo_ff;

endmodule

/* rtl/core/rcc_merge.sv */
// Merge stage: picks the first failing axis and packs the resize word.
module rcc_merge
   import rcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lane_res_type h_res,
   input  lane_res_type w_res,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   logic         valid_ff;
   rsp_type      item_ff, item_in;
   err_code_type err;

   always_comb begin
      err = (h_res.err != ERR_NONE) ? h_res.err : w_res.err;
      item_in.error_code = err;
      if (err == ERR_NONE) begin
         item_in.resize_word = {h_res.shift, h_res.coef, w_res.shift, w_res.coef};
      end else begin
         item_in.resize_word = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= h_res.done;
      end
      if (h_res.done) begin
         item_ff <= item_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

/* rtl/core/resize_coefficient_calc_core.sv */
// Top level of the resize coefficient calculator: height and width lanes plus merge.
//
//   channel   handshake          payload
//   request   start / busy       req_item  (req_type)
//   response  rsp_valid strobe   rsp_item  (rsp_type)
//
// An item passes from accept through the 14-step restoring divider in each lane,
// both lanes stepping together, to the lane done register and the registered
// rsp_valid strobe; busy falls in the cycle after the strobe. Synchronous reset clears control
// state only. The receiver cannot stall; each result shows for one cycle.
module resize_coefficient_calc_core
   import rcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   logic         busy_ff, busy_in;
   logic         load;
   lane_res_type h_res, w_res;

   assign load = start && !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (rsp_valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

   rcc_lane u_lane_h (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .in_size  (req_item.in_height),
      .out_size (req_item.out_height),
      .res      (h_res)
   );

   rcc_lane u_lane_w (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .in_size  (req_item.in_width),
      .out_size (req_item.out_width),
      .res      (w_res)
   );

   rcc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .h_res     (h_res),
      .w_res     (w_res),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
